// ===== hdl/tccw_pkg.sv =====
// ----------------------------------------------------------------------------
// tccw_pkg
// Shared types and constants for the text console cursor writer.
// ----------------------------------------------------------------------------
package tccw_pkg;

  localparam int DEF_SCREEN_COLUMNS = 80;
  localparam int DEF_SCREEN_ROWS    = 25;

  localparam int NUMBER_W   = 32;
  localparam int CELL_W     = 11;
  localparam int DIGIT_W    = 4;
  localparam int MAX_DIGITS = 10;
  localparam int DCNT_W     = $clog2(MAX_DIGITS);

  // Exact floor(n / 10) for any 32-bit n: (n * 0xCCCCCCCD) >> 35.
  localparam logic [NUMBER_W-1:0] RECIP_TEN   = 32'hCCCC_CCCD;
  localparam int                  RECIP_SHIFT = 35;

  localparam logic [7:0] TEXT_COLOR_RESET = 8'h0F;

  localparam logic [1:0] CMD_CHAR   = 2'd0;
  localparam logic [1:0] CMD_NUMBER = 2'd1;
  localparam logic [1:0] CMD_CLEAR  = 2'd2;

  localparam logic [7:0] CHAR_NUL   = 8'h00;
  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;

  typedef struct packed {
    logic [1:0]          command;
    logic [7:0]          char_code;
    logic [NUMBER_W-1:0] number;
    logic [7:0]          fill_color;
  } in_item_t;

  typedef struct packed {
    logic [CELL_W-1:0] cell_index;
    logic [7:0]        glyph;
    logic [7:0]        attribute;
    logic              fill_screen;
    logic              last;
  } out_item_t;

  typedef struct packed {
    logic load;
    logic exec_char;
    logic conv_step;
    logic emit_step;
  } ctrl_cmd_t;

  typedef struct packed {
    logic in_is_number;
    logic conv_done;
    logic emit_done;
    logic slot_free;
  } dp_status_t;

endpackage

// ===== hdl/tccw_ctrl.sv =====
// ----------------------------------------------------------------------------
// tccw_ctrl
// Sequencer: accepts a command, executes a character or clear, or runs digit extraction and digit output.
// ----------------------------------------------------------------------------
module tccw_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  tccw_pkg::dp_status_t status,
  output tccw_pkg::ctrl_cmd_t  cmd
);
  import tccw_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_CHAR = 4'b0010,
    ST_CONV = 4'b0100,
    ST_EMIT = 4'b1000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = status.in_is_number ? ST_CONV : ST_CHAR;
        end
      end
      ST_CHAR: begin
        if (status.slot_free) begin
          cmd.exec_char = 1'b1;
          state_next    = ST_IDLE;
        end
      end
      ST_CONV: begin
        cmd.conv_step = 1'b1;
        if (status.conv_done) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (status.slot_free) begin
          cmd.emit_step = 1'b1;
          if (status.emit_done) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== hdl/tccw_datapath.sv =====
// ----------------------------------------------------------------------------
// tccw_datapath
// Cursor, color register, decimal digit extraction and result register.
// ----------------------------------------------------------------------------
module tccw_datapath #(
  parameter int SCREEN_COLUMNS = tccw_pkg::DEF_SCREEN_COLUMNS,
  parameter int SCREEN_ROWS    = tccw_pkg::DEF_SCREEN_ROWS
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic [7:0]           cfg_data,
  input  tccw_pkg::in_item_t   in_data,
  input  tccw_pkg::ctrl_cmd_t  cmd,
  output tccw_pkg::dp_status_t status,
  output logic                 out_valid,
  input  logic                 out_ready,
  output tccw_pkg::out_item_t  out_data
);
  import tccw_pkg::*;

  localparam int CW = $clog2(SCREEN_COLUMNS);
  localparam int RW = $clog2(SCREEN_ROWS + 1);
  localparam int PW = (RW + CW + 1 > CELL_W) ? RW + CW + 1 : CELL_W;
  localparam int QW = 2 * NUMBER_W - RECIP_SHIFT;

  logic [7:0]          text_color;
  logic [CW-1:0]       col;
  logic [RW-1:0]       row;
  logic [1:0]          cmd_q;
  logic [7:0]          char_q;
  logic [7:0]          fill_q;
  logic [NUMBER_W-1:0] num;
  logic [DCNT_W-1:0]   cnt;
  logic [DIGIT_W-1:0]  digit_store [MAX_DIGITS];

  // Decimal extraction, least significant digit first.
  logic [2*NUMBER_W-1:0] prod;
  logic [QW-1:0]         quot;
  logic [NUMBER_W-1:0]   quot10;
  logic [NUMBER_W-1:0]   rem;

  assign prod   = {{NUMBER_W{1'b0}}, num} * {{NUMBER_W{1'b0}}, RECIP_TEN};
  assign quot   = prod[2*NUMBER_W-1:RECIP_SHIFT];
  assign quot10 = NUMBER_W'({quot, 3'b000}) + NUMBER_W'({quot, 1'b0});
  assign rem    = num - quot10;

  // Cursor arithmetic shared by characters and digits.
  logic            on_screen;
  logic [CW:0]     col_inc;
  logic            wrap;
  logic [RW-1:0]   row_adv;
  logic [CW-1:0]   col_g;
  logic [RW-1:0]   row_g;
  logic [PW-1:0]   cell_full;

  assign on_screen = row < RW'(SCREEN_ROWS);
  assign col_inc   = {1'b0, col} + (CW+1)'(1);
  assign wrap      = col_inc >= (CW+1)'(SCREEN_COLUMNS);
  assign row_adv   = on_screen ? row + RW'(1) : row;
  assign col_g     = wrap ? '0 : col_inc[CW-1:0];
  assign row_g     = wrap ? row_adv : row;
  assign cell_full = PW'(row) * PW'(SCREEN_COLUMNS) + PW'(col);

  logic       is_char, is_ctrl_char, do_put, do_nl, do_clear, load_out, last_put;
  logic [7:0] glyph_sel;

  assign is_char      = cmd.exec_char && (cmd_q == CMD_CHAR);
  assign is_ctrl_char = (char_q == CHAR_NUL) || (char_q == CHAR_LF) || (char_q == CHAR_CR);
  assign do_put       = (is_char && !is_ctrl_char) || cmd.emit_step;
  assign do_nl        = is_char && ((char_q == CHAR_LF) || (char_q == CHAR_CR));
  assign do_clear     = cmd.exec_char && (cmd_q == CMD_CLEAR);
  assign load_out     = (do_put && on_screen) || do_clear;
  assign glyph_sel    = cmd.emit_step ? CHAR_ZERO + 8'(digit_store[cnt]) : char_q;
  // A digit is the last beat when no later digit can land on the screen.
  assign last_put     = !cmd.emit_step || (cnt == '0) ||
                        (wrap && (row_adv == RW'(SCREEN_ROWS)));

  assign status.in_is_number = in_data.command == CMD_NUMBER;
  assign status.conv_done    = (quot == '0) || (cnt == DCNT_W'(MAX_DIGITS - 1));
  assign status.emit_done    = cnt == '0;
  assign status.slot_free    = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      text_color <= TEXT_COLOR_RESET;
      col        <= '0;
      row        <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_write) begin
        text_color <= cfg_data;
      end
      if (do_clear) begin
        col <= '0;
        row <= '0;
      end else if (do_nl) begin
        col <= '0;
        row <= row_adv;
      end else if (do_put) begin
        col <= col_g;
        row <= row_g;
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_q  <= in_data.command;
      char_q <= in_data.char_code;
      fill_q <= in_data.fill_color;
      num    <= in_data.number;
      cnt    <= '0;
    end else if (cmd.conv_step) begin
      digit_store[cnt] <= rem[DIGIT_W-1:0];
      num              <= NUMBER_W'(quot);
      if (!status.conv_done) begin
        cnt <= cnt + DCNT_W'(1);
      end
    end else if (cmd.emit_step && cnt != '0) begin
      cnt <= cnt - DCNT_W'(1);
    end
    if (load_out) begin
      if (do_clear) begin
        out_data.cell_index  <= '0;
        out_data.glyph       <= CHAR_SPACE;
        out_data.attribute   <= fill_q;
        out_data.fill_screen <= 1'b1;
        out_data.last        <= 1'b1;
      end else begin
        out_data.cell_index  <= cell_full[CELL_W-1:0];
        out_data.glyph       <= glyph_sel;
        out_data.attribute   <= text_color;
        out_data.fill_screen <= 1'b0;
        out_data.last        <= last_put;
      end
    end
  end

  a_row_bound: assert property (@(posedge clk) disable iff (rst)
    row <= RW'(SCREEN_ROWS))
    else $error("cursor row beyond the row count");

  a_col_bound: assert property (@(posedge clk) disable iff (rst)
    col_inc <= (CW+1)'(SCREEN_COLUMNS))
    else $error("cursor column beyond the row end");

  a_fill_beat: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.fill_screen |->
      out_data.cell_index == '0 && out_data.glyph == CHAR_SPACE && out_data.last)
    else $error("fill beat malformed");

  a_digit_count: assert property (@(posedge clk) disable iff (rst)
    cmd.conv_step || cmd.emit_step |-> cnt < DCNT_W'(MAX_DIGITS))
    else $error("digit index out of range");

endmodule

// ===== hdl/text_console_cursor_writer_core.sv =====
// ----------------------------------------------------------------------------
// text_console_cursor_writer_core
// Text console front end: turns print and clear commands into cell writes.
// ----------------------------------------------------------------------------
// Usage: an input beat carries a command (print character, print decimal
// number, clear screen) with its operands. Each output beat is one cell write
// (cell index, glyph, attribute) or one fill of the whole screen; the final
// beat caused by a command has last set. NUL, newline, carriage return and
// writes below the bottom row produce no beat.
// Sequencing: the block works on one command at a time. A character or clear
// is latched on accept and then executed into the output register once that
// register is free. A number is first split into digits, one reciprocal
// multiply per digit, and the digits then go out most significant first.
// The output register holds a finished beat while the next command is taken.
// When the receiver stalls, the sequencer waits with the next beat until the
// output register is free; no beat is lost.
// Reset (synchronous): cursor homes to column 0, row 0, text color becomes
// 0x0F and the output channel goes idle. The color register may be written
// at any time the block is idle and takes effect on the next command.
// ----------------------------------------------------------------------------
module text_console_cursor_writer_core #(
  parameter int SCREEN_COLUMNS = tccw_pkg::DEF_SCREEN_COLUMNS,
  parameter int SCREEN_ROWS    = tccw_pkg::DEF_SCREEN_ROWS
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_write,
  input  logic [7:0]          cfg_data,
  input  logic                in_valid,
  output logic                in_ready,
  input  tccw_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output tccw_pkg::out_item_t out_data
);
  import tccw_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  tccw_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  tccw_datapath #(
    .SCREEN_COLUMNS (SCREEN_COLUMNS),
    .SCREEN_ROWS    (SCREEN_ROWS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
